/* hdl/conflict_aware_work_dispatcher_assert.svh */
// Assertion macros for the work dispatcher checker.
// Each macro expects clk and rst_n in scope.
`ifndef CONFLICT_AWARE_WORK_DISPATCHER_ASSERT_SVH
`define CONFLICT_AWARE_WORK_DISPATCHER_ASSERT_SVH

// Same-cycle implication.
`define CAWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher check failed");

// Next-cycle implication.
`define CAWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher check failed");

`endif

/* hdl/cawd_pkg.sv */
// ----------------------------------------------------------------------------
// cawd_pkg
// Types and constants shared by the work dispatcher modules.
// ----------------------------------------------------------------------------
package cawd_pkg;

    localparam int MAX_PKG    = 64;
    localparam int PKG_W      = 6;
    localparam int NP_W       = 7;
    localparam int RES_BITS   = 64;
    localparam int RB_W       = 6;
    localparam int MAX_WRK    = 8;
    localparam int WRK_W      = 3;
    localparam int WCFG_W     = 4;
    localparam int CNT_W      = 7;
    localparam int TOT_W      = 7;
    localparam int ELEM_W     = 17;
    localparam int EPP_SHIFT  = 10;
    localparam int EPR_SHIFT  = 10;

    localparam logic [ELEM_W-1:0] ELEM_LIMIT = ELEM_W'(MAX_PKG * (2 ** EPP_SHIFT));
    localparam logic [ELEM_W-1:0] RES_LIMIT  = ELEM_W'(RES_BITS * (2 ** EPR_SHIFT));

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_REQ   = 3'd3;
    localparam logic [2:0] OP_REL   = 3'd4;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_GRANTED = 3'd1;
    localparam logic [2:0] ST_WAIT    = 3'd2;
    localparam logic [2:0] ST_ALL     = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    localparam logic [1:0] CFG_ELEM_COUNT  = 2'd0;
    localparam logic [1:0] CFG_WORKER_CNT  = 2'd1;
    localparam logic [1:0] CFG_CHECK_CONFL = 2'd2;

    typedef enum logic [3:0] {
        C_NONE,
        C_LOAD,
        C_SIMPLE,
        C_ADD_RD,
        C_ADD_WR,
        C_UNION,
        C_SCAN,
        C_FIN,
        C_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic add_go;
        logic req_go;
        logic union_last;
        logic scan_done;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [RES_BITS-1:0] mask;
        logic [CNT_W-1:0]    cnt;
    } entry_t;

endpackage

/* hdl/conflict_aware_work_dispatcher.sv */
// ----------------------------------------------------------------------------
// conflict_aware_work_dispatcher
// Hands out work packages by mask priority while avoiding resource conflicts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: clear,
//   add dependency, start round, request or release. Every beat yields
//   exactly one result beat on the output channel (out_valid / out_stall).
//   Config channel (cfg_valid, cfg_ready always 1), unchecked by the block:
//   the user writes element_count, worker_count and check_conflicts in idle.
// Steps from accept to result valid:
//   clear, start, release, rejected commands: decode, then the output register.
//   add dependency: read-modify-write of the mask memory.
//   request: the mask memory read port walks the held packages of all worker
//   slots once, then every package once.
// Commands are handled one at a time; in_stall drops once the result has
// moved into the output register, so the next beat is taken while the
// previous result still waits. A stalled receiver holds the result beat and,
// after the next command finishes, the block waits for the register to free.
// Reset: all masks, flags and holds read as empty; config returns to 1/1/1.
// ----------------------------------------------------------------------------
module conflict_aware_work_dispatcher
    import cawd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [ELEM_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        operation,
    input  logic [ELEM_W-1:0] element_index,
    input  logic [ELEM_W-1:0] resource_element_index,
    input  logic [WRK_W-1:0]  worker,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [PKG_W-1:0]  package_res,
    output logic [ELEM_W-1:0] first_element,
    output logic [ELEM_W-1:0] last_element
);

    logic [ELEM_W-1:0] elem_count_reg;
    logic [WCFG_W-1:0] worker_count_reg;
    logic              check_conf_reg;
    cmd_t              cmd;
    stat_t             stat;

    // config registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count_reg   <= ELEM_W'(1);
            worker_count_reg <= WCFG_W'(1);
            check_conf_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ELEM_COUNT:  elem_count_reg   <= cfg_data;
                CFG_WORKER_CNT:  worker_count_reg <= cfg_data[WCFG_W-1:0];
                CFG_CHECK_CONFL: check_conf_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    cawd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cawd_datapath u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .stat                   (stat),
        .element_count          (elem_count_reg),
        .worker_count           (worker_count_reg),
        .check_conflicts        (check_conf_reg),
        .operation              (operation),
        .element_index          (element_index),
        .resource_element_index (resource_element_index),
        .worker                 (worker),
        .out_stall              (out_stall),
        .out_valid              (out_valid),
        .status                 (status),
        .package_res            (package_res),
        .first_element          (first_element),
        .last_element           (last_element)
    );

endmodule

/* hdl/cawd_ctrl.sv */
// ----------------------------------------------------------------------------
// cawd_ctrl
// Sequencer that steps the datapath through one operation at a time.
// ----------------------------------------------------------------------------
module cawd_ctrl
    import cawd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_UNION,
        S_SCAN,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = C_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.op     = C_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.add_go)
                begin
                    cmd.op     = C_ADD_RD;
                    state_next = S_ADD;
                end
                else if (stat.req_go)
                begin
                    cmd.op     = C_UNION;
                    state_next = stat.union_last ? S_SCAN : S_UNION;
                end
                else
                begin
                    cmd.op     = C_SIMPLE;
                    state_next = S_OUT;
                end
            end
            S_ADD:
            begin
                cmd.op     = C_ADD_WR;
                state_next = S_OUT;
            end
            S_UNION:
            begin
                cmd.op = C_UNION;
                if (stat.union_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = C_SCAN;
                if (stat.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.op     = C_FIN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = C_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

/* hdl/cawd_datapath.sv */
// ----------------------------------------------------------------------------
// cawd_datapath
// Mask memory, dispatch flags, worker holds, priority scan and result register.
// ----------------------------------------------------------------------------
module cawd_datapath
    import cawd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [ELEM_W-1:0] element_count,
    input  logic [WCFG_W-1:0] worker_count,
    input  logic              check_conflicts,
    input  logic [2:0]        operation,
    input  logic [ELEM_W-1:0] element_index,
    input  logic [ELEM_W-1:0] resource_element_index,
    input  logic [WRK_W-1:0]  worker,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [2:0]        status,
    output logic [PKG_W-1:0]  package_res,
    output logic [ELEM_W-1:0] first_element,
    output logic [ELEM_W-1:0] last_element
);

    typedef enum logic [1:0] {RK_NONE, RK_UNION, RK_SCAN, RK_ADD} rd_kind_t;

    // item and scan registers
    logic [2:0]          op_reg;
    logic [ELEM_W-1:0]   e_reg, r_reg;
    logic [WRK_W-1:0]    wk_reg;
    logic [NP_W-1:0]     np_reg;
    logic [NP_W-1:0]     cnt_reg;
    logic [RES_BITS-1:0] union_reg;
    logic                found_reg;
    logic [PKG_W-1:0]    best_reg;
    logic [CNT_W-1:0]    best_cnt_reg;
    rd_kind_t            rd_kind_reg;
    logic [PKG_W-1:0]    rd_idx_reg;
    logic [2:0]          res_status_reg;
    logic [PKG_W-1:0]    res_pkg_reg;
    logic [ELEM_W-1:0]   res_first_reg, res_last_reg;

    // dispatcher state
    entry_t              mem [MAX_PKG];
    entry_t              rdata_reg;
    logic                rvalid_reg;
    logic [MAX_PKG-1:0]  vld_reg;
    logic [MAX_PKG-1:0]  disp_reg;
    logic [MAX_WRK-1:0]  hold_reg;
    logic [PKG_W-1:0]    wpkg_reg [MAX_WRK];
    logic [TOT_W-1:0]    total_reg;

    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    logic [PKG_W-1:0]    out_pkg_reg;
    logic [ELEM_W-1:0]   out_first_reg, out_last_reg;

    logic [WCFG_W-1:0]   act;
    logic                wk_ok, add_bad;
    logic [PKG_W-1:0]    p_idx;
    logic [RB_W-1:0]     b_idx;
    logic [PKG_W-1:0]    rd_addr;
    logic [RES_BITS-1:0] cur_mask, bitv;
    logic [CNT_W-1:0]    cur_cnt;
    logic                take_cand, union_pend, mem_we;
    logic [ELEM_W:0]     ec_sum;
    logic [ELEM_W-EPP_SHIFT:0] np_raw;
    logic [NP_W-1:0]     np_calc;
    logic [WRK_W-1:0]    j_idx;
    logic [2:0]          simple_status;
    logic [ELEM_W-1:0]   g_first, g_end, g_last;

    always_comb
    begin
        act     = (worker_count > WCFG_W'(MAX_WRK)) ? WCFG_W'(MAX_WRK) : worker_count;
        wk_ok   = ({1'b0, wk_reg} < act);
        add_bad = (e_reg == '0) || (e_reg > element_count) || (e_reg > ELEM_LIMIT) ||
                  (r_reg == '0) || (r_reg > RES_LIMIT);
        p_idx   = PKG_W'((e_reg - ELEM_W'(1)) >> EPP_SHIFT);
        b_idx   = RB_W'((r_reg - ELEM_W'(1)) >> EPR_SHIFT);
        bitv    = RES_BITS'(1) << b_idx;
        j_idx   = cnt_reg[WRK_W-1:0];

        ec_sum  = {1'b0, element_count} + (ELEM_W+1)'((2 ** EPP_SHIFT) - 1);
        np_raw  = (ELEM_W-EPP_SHIFT+1)'(ec_sum >> EPP_SHIFT);
        np_calc = (np_raw > (ELEM_W-EPP_SHIFT+1)'(MAX_PKG)) ? NP_W'(MAX_PKG)
                                                           : NP_W'(np_raw);

        union_pend = check_conflicts && (j_idx != wk_reg) && hold_reg[j_idx] &&
                     ({1'b0, j_idx} < act);

        case (cmd.op)
            C_ADD_RD: rd_addr = p_idx;
            C_UNION:  rd_addr = wpkg_reg[j_idx];
            C_SCAN:   rd_addr = cnt_reg[PKG_W-1:0];
            default:  rd_addr = '0;
        endcase

        cur_mask  = rvalid_reg ? rdata_reg.mask : '0;
        cur_cnt   = rvalid_reg ? rdata_reg.cnt : '0;
        take_cand = (rd_kind_reg == RK_SCAN) && !disp_reg[rd_idx_reg] &&
                    (!check_conflicts || ((cur_mask & union_reg) == '0)) &&
                    (!found_reg || (cur_cnt > best_cnt_reg));
        mem_we    = (cmd.op == C_ADD_WR) && ((cur_mask & bitv) == '0);

        case (op_reg)
            OP_ADD:  simple_status = ST_RANGE;
            OP_REQ:  simple_status = ST_RANGE;
            OP_REL:  simple_status = wk_ok ? ST_DONE : ST_RANGE;
            default: simple_status = ST_DONE;
        endcase

        g_first = (ELEM_W'(best_reg) << EPP_SHIFT) + ELEM_W'(1);
        g_end   = (ELEM_W'(best_reg) + ELEM_W'(1)) << EPP_SHIFT;
        g_last  = (g_end > element_count) ? element_count : g_end;

        stat.add_go     = (op_reg == OP_ADD) && !add_bad;
        stat.req_go     = (op_reg == OP_REQ) && wk_ok;
        stat.union_last = (cnt_reg == NP_W'(MAX_WRK - 1));
        stat.scan_done  = (cnt_reg >= np_reg);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // mask memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[p_idx] <= '{mask: cur_mask | bitv, cnt: cur_cnt + CNT_W'(1)};
        end
        rdata_reg <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg    <= 1'b0;
            vld_reg       <= '0;
            disp_reg      <= '0;
            hold_reg      <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            rd_kind_reg   <= RK_NONE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_WRK; i++)
            begin
                wpkg_reg[i] <= '0;
            end
        end
        else
        begin
            rvalid_reg <= vld_reg[rd_addr];
            if (take_cand)
            begin
                found_reg <= 1'b1;
            end
            if (mem_we)
            begin
                vld_reg[p_idx] <= 1'b1;
            end
            if (out_valid_reg && !out_stall && (cmd.op != C_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                C_ADD_RD: rd_kind_reg <= RK_ADD;
                C_UNION:  rd_kind_reg <= union_pend ? RK_UNION : RK_NONE;
                C_SCAN:   rd_kind_reg <= stat.scan_done ? RK_NONE : RK_SCAN;
                default:  rd_kind_reg <= RK_NONE;
            endcase

            case (cmd.op)
                C_LOAD:
                begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                end
                C_SIMPLE:
                begin
                    if (op_reg == OP_CLEAR)
                    begin
                        vld_reg <= '0;
                    end
                    else if (op_reg == OP_START)
                    begin
                        disp_reg  <= '0;
                        hold_reg  <= '0;
                        total_reg <= '0;
                    end
                    else if (op_reg == OP_REL && wk_ok)
                    begin
                        hold_reg[wk_reg] <= 1'b0;
                    end
                end
                C_UNION:
                begin
                    cnt_reg <= stat.union_last ? '0 : cnt_reg + NP_W'(1);
                end
                C_SCAN:
                begin
                    if (!stat.scan_done)
                    begin
                        cnt_reg <= cnt_reg + NP_W'(1);
                    end
                end
                C_FIN:
                begin
                    hold_reg[wk_reg] <= found_reg;
                    if (found_reg)
                    begin
                        disp_reg[best_reg] <= 1'b1;
                        total_reg          <= total_reg + TOT_W'(1);
                        wpkg_reg[wk_reg]   <= best_reg;
                    end
                end
                C_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[PKG_W-1:0];
        if (rd_kind_reg == RK_UNION)
        begin
            union_reg <= union_reg | cur_mask;
        end
        if (take_cand)
        begin
            best_reg     <= rd_idx_reg;
            best_cnt_reg <= cur_cnt;
        end
        case (cmd.op)
            C_LOAD:
            begin
                op_reg    <= operation;
                e_reg     <= element_index;
                r_reg     <= resource_element_index;
                wk_reg    <= worker;
                np_reg    <= np_calc;
                union_reg <= '0;
            end
            C_SIMPLE, C_ADD_WR:
            begin
                res_status_reg <= (cmd.op == C_SIMPLE) ? simple_status : ST_DONE;
                res_pkg_reg    <= '0;
                res_first_reg  <= '0;
                res_last_reg   <= '0;
            end
            C_FIN:
            begin
                if (found_reg)
                begin
                    res_status_reg <= ST_GRANTED;
                    res_pkg_reg    <= best_reg;
                    res_first_reg  <= g_first;
                    res_last_reg   <= g_last;
                end
                else
                begin
                    res_status_reg <= (total_reg >= np_reg) ? ST_ALL : ST_WAIT;
                    res_pkg_reg    <= '0;
                    res_first_reg  <= '0;
                    res_last_reg   <= '0;
                end
            end
            C_OUT:
            begin
                out_status_reg <= res_status_reg;
                out_pkg_reg    <= res_pkg_reg;
                out_first_reg  <= res_first_reg;
                out_last_reg   <= res_last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign package_res   = out_pkg_reg;
    assign first_element = out_first_reg;
    assign last_element  = out_last_reg;

endmodule

/* hdl/cawd_checker.sv */
// ----------------------------------------------------------------------------
// cawd_checker
// Port-level checks on the work dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "conflict_aware_work_dispatcher_assert.svh"

module cawd_checker
    import cawd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [2:0]        status,
    input logic [PKG_W-1:0]  package_res,
    input logic [ELEM_W-1:0] first_element,
    input logic [ELEM_W-1:0] last_element
);

    // a stalled result beat holds
    `CAWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
    // one command at a time: busy right after an accept
    `CAWD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // only a grant carries package fields
    `CAWD_ASSERT_NOW(a_zero_fields, out_valid && status != ST_GRANTED,
        package_res == '0 && first_element == '0 && last_element == '0)
    // a grant starts at the package boundary and does not run backward
    `CAWD_ASSERT_NOW(a_grant_range, out_valid && status == ST_GRANTED,
        first_element == (ELEM_W'(package_res) << EPP_SHIFT) + ELEM_W'(1) &&
        last_element >= first_element)

endmodule

bind conflict_aware_work_dispatcher cawd_checker u_cawd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .package_res   (package_res),
    .first_element (first_element),
    .last_element  (last_element)
);
